// ===== src/swrl_pkg.sv =====
`timescale 1ns / 1ps

package swrl_pkg;

    localparam int NUM_EVENTS = 16;
    localparam int HIST_DEPTH = 128;

    localparam int EVENT_W = 4;
    localparam int TS_W    = 31;
    localparam int LIMIT_W = 8;
    localparam int UNIT_W  = 2;
    localparam int WIN_W   = 17;
    localparam int SUM_W   = TS_W + 1;

    localparam int EV_IDX_W   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
    localparam int CMP_W      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int ADDR_W     = EV_IDX_W + HIST_IDX_W;
    localparam int MEM_DEPTH  = NUM_EVENTS * (2 ** HIST_IDX_W);

    localparam logic [UNIT_W-1:0] UNIT_SECOND = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_MINUTE = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_HOUR   = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_DAY    = 2'd3;

    localparam logic [WIN_W-1:0] WIN_SECOND = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_MINUTE = WIN_W'(60);
    localparam logic [WIN_W-1:0] WIN_HOUR   = WIN_W'(60 * 60);
    localparam logic [WIN_W-1:0] WIN_DAY    = WIN_W'(60 * 60 * 24);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [EVENT_W-1:0] event_id;
        logic [TS_W-1:0]    timestamp;
        logic [LIMIT_W-1:0] limit_count;
        logic [UNIT_W-1:0]  window_unit;
        logic               record_hit;
    } t_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [TS_W-1:0]   wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [WIN_W-1:0] window_len(input logic [UNIT_W-1:0] unit);
        logic [WIN_W-1:0] len;
        unique case (unit)
            UNIT_SECOND: len = WIN_SECOND;
            UNIT_MINUTE: len = WIN_MINUTE;
            UNIT_HOUR:   len = WIN_HOUR;
            UNIT_DAY:    len = WIN_DAY;
            default:     len = WIN_SECOND;
        endcase
        return len;
    endfunction

endpackage

// ===== src/swrl_if.sv =====
`timescale 1ns / 1ps

interface swrl_req_if;
    logic                            valid;
    logic                            ready;
    logic [swrl_pkg::EVENT_W-1:0]    event_id;
    logic [swrl_pkg::TS_W-1:0]       timestamp;
    logic [swrl_pkg::LIMIT_W-1:0]    limit_count;
    logic [swrl_pkg::UNIT_W-1:0]     window_unit;
    logic                            record_hit;

    modport source (
        output valid, event_id, timestamp, limit_count, window_unit, record_hit,
        input  ready
    );
    modport sink (
        input  valid, event_id, timestamp, limit_count, window_unit, record_hit,
        output ready
    );
endinterface

interface swrl_rsp_if;
    logic valid;
    logic ready;
    logic limited;

    modport source (
        output valid, limited,
        input  ready
    );
    modport sink (
        input  valid, limited,
        output ready
    );
endinterface

// ===== src/swrl_ram.sv =====
`timescale 1ns / 1ps

module swrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/swrl_ctrl.sv =====
`timescale 1ns / 1ps

module swrl_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  swrl_pkg::t_req           i_req,
    output logic                     o_res_valid,
    output logic                     o_res_limited,
    input  logic                     i_res_ready,
    output swrl_pkg::t_ram_req       o_ram,
    input  logic [swrl_pkg::TS_W-1:0] i_ram_rdata
);
    import swrl_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [EV_IDX_W-1:0]   r_ev;
    logic [TS_W-1:0]       r_ts;
    logic [WIN_W-1:0]      r_win;
    logic [CNT_W-1:0]      r_lim;
    logic                  r_rec;
    logic                  r_bad;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_pend;
    logic [CNT_W-1:0]      r_total;

    logic [HIST_IDX_W-1:0] r_wp_tab   [NUM_EVENTS];
    logic [CNT_W-1:0]      r_fill_tab [NUM_EVENTS];

    logic                  accept;
    logic                  in_bad;
    logic [CMP_W-1:0]      lim_wide;
    logic [CNT_W-1:0]      fill_cur;
    logic [HIST_IDX_W-1:0] wp_cur;
    logic                  rd_issue;
    logic                  hit;
    logic                  limited;
    logic                  do_write;

    assign accept   = i_req_valid && o_req_ready;
    assign in_bad   = int'(i_req.event_id) >= NUM_EVENTS;
    assign lim_wide = CMP_W'(i_req.limit_count);
    assign fill_cur = r_fill_tab[r_ev];
    assign wp_cur   = r_wp_tab[r_ev];
    assign rd_issue = (r_state == ST_SCAN) && (r_idx < fill_cur);
    assign hit      = (SUM_W'(i_ram_rdata) + SUM_W'(r_win)) > SUM_W'(r_ts);
    assign limited  = !r_bad && (r_total >= r_lim);
    assign do_write = (r_state == ST_FINISH) && i_res_ready && !r_bad && r_rec && !limited;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_bad ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!rd_issue && !r_pend) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready   = (r_state == ST_IDLE);
        o_res_valid   = (r_state == ST_FINISH);
        o_res_limited = limited;
        o_ram.re      = rd_issue;
        o_ram.raddr   = {r_ev, r_idx[HIST_IDX_W-1:0]};
        o_ram.we      = do_write;
        o_ram.waddr   = {r_ev, wp_cur};
        o_ram.wdata   = r_ts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            for (int e = 0; e < NUM_EVENTS; e++) begin
                r_wp_tab[e]   <= '0;
                r_fill_tab[e] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= rd_issue;
            if (do_write) begin
                if (int'(wp_cur) == HIST_DEPTH - 1) begin
                    r_wp_tab[r_ev] <= '0;
                end else begin
                    r_wp_tab[r_ev] <= wp_cur + 1'b1;
                end
                if (int'(fill_cur) < HIST_DEPTH) begin
                    r_fill_tab[r_ev] <= fill_cur + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ev    <= EV_IDX_W'(i_req.event_id);
            r_ts    <= i_req.timestamp;
            r_win   <= window_len(i_req.window_unit);
            r_rec   <= i_req.record_hit;
            r_bad   <= in_bad;
            r_idx   <= '0;
            r_total <= '0;
            if (lim_wide > CMP_W'(HIST_DEPTH)) begin
                r_lim <= CNT_W'(HIST_DEPTH);
            end else begin
                r_lim <= CNT_W'(lim_wide);
            end
        end else begin
            if (rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend && hit) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

endmodule

// ===== src/sliding_window_rate_limiter_unit.sv =====
`timescale 1ns / 1ps

// Sliding-window log rate limiter. Each event class keeps a ring of the
// timestamps of its recorded hits in one single-port-read memory; a request
// reads the valid stamps of its class one per cycle, counts those still
// inside the window and answers limited when that count reaches the limit.
// A request reads as many stamps as its class's fill count, up to a full ring
// of 128 stamps, with the one memory read a cycle setting its length;
// requests are handled one at a time. The result sits in an output register,
// so the next request transfer is taken while a result still waits.
// The timestamp memory needs no clearing after reset.
module sliding_window_rate_limiter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swrl_req_if.sink    i_req,
    swrl_rsp_if.source  o_rsp
);
    import swrl_pkg::*;

    t_req             req;
    t_ram_req         ram;
    logic [TS_W-1:0]  ram_rdata;
    logic             res_valid;
    logic             res_limited;
    logic             res_ready;
    logic             r_out_valid;
    logic             r_out_limited;

    assign req.event_id    = i_req.event_id;
    assign req.timestamp   = i_req.timestamp;
    assign req.limit_count = i_req.limit_count;
    assign req.window_unit = i_req.window_unit;
    assign req.record_hit  = i_req.record_hit;

    assign res_ready = !r_out_valid || o_rsp.ready;

    swrl_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .o_req_ready   (i_req.ready),
        .i_req         (req),
        .o_res_valid   (res_valid),
        .o_res_limited (res_limited),
        .i_res_ready   (res_ready),
        .o_ram         (ram),
        .i_ram_rdata   (ram_rdata)
    );

    swrl_ram #(
        .WIDTH (TS_W),
        .DEPTH (MEM_DEPTH)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_limited <= res_limited;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.limited = r_out_limited;

endmodule
